// ===== hdl/lps_pkg.sv =====
// Package for the primary-station link controller: state, event and
// command codes, and the result word type. No dependencies.
package lps_pkg;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_UNCONF_TXW  = 3'd1,
    ST_RESET_TXW   = 3'd2,
    ST_CONF_TXW    = 3'd3,
    ST_STATUS_TXW  = 3'd4,
    ST_RESET_WAIT  = 3'd5,
    ST_CONF_WAIT   = 3'd6,
    ST_STATUS_WAIT = 3'd7
  } lps_state_t;

  // Event codes carried in req_type.
  localparam logic [3:0] EV_SEND_CONF     = 4'd0;
  localparam logic [3:0] EV_SEND_UNCONF   = 4'd1;
  localparam logic [3:0] EV_REQ_STATUS    = 4'd2;
  localparam logic [3:0] EV_TX_DONE       = 4'd3;
  localparam logic [3:0] EV_ACK           = 4'd4;
  localparam logic [3:0] EV_NACK          = 4'd5;
  localparam logic [3:0] EV_LINK_STATUS   = 4'd6;
  localparam logic [3:0] EV_NOT_SUPPORTED = 4'd7;
  localparam logic [3:0] EV_TIMEOUT       = 4'd8;

  // Frame to queue.
  localparam logic [2:0] FRM_NONE        = 3'd0;
  localparam logic [2:0] FRM_UNCONF_DATA = 3'd1;
  localparam logic [2:0] FRM_CONF_DATA   = 3'd2;
  localparam logic [2:0] FRM_RESET_LINKS = 3'd3;
  localparam logic [2:0] FRM_REQ_STATUS  = 3'd4;

  // Response timer command.
  localparam logic [1:0] TMR_NONE   = 2'd0;
  localparam logic [1:0] TMR_START  = 2'd1;
  localparam logic [1:0] TMR_CANCEL = 2'd2;

  // Send outcome.
  localparam logic [1:0] SEND_NONE = 2'd0;
  localparam logic [1:0] SEND_OK   = 2'd1;
  localparam logic [1:0] SEND_FAIL = 2'd2;

  // Keep-alive outcome.
  localparam logic [1:0] KA_NONE         = 2'd0;
  localparam logic [1:0] KA_DONE         = 2'd1;
  localparam logic [1:0] KA_FAIL         = 2'd2;
  localparam logic [1:0] KA_FAIL_TIMEOUT = 2'd3;

  // Link status report.
  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_RESET   = 2'd1;
  localparam logic [1:0] STAT_UNRESET = 2'd2;

  // Event fault code.
  localparam logic [1:0] FLT_NONE       = 2'd0;
  localparam logic [1:0] FLT_UNEXPECTED = 2'd1;
  localparam logic [1:0] FLT_INVALID    = 2'd2;

  typedef struct packed {
    lps_state_t state_after;
    logic [2:0] frame_cmd;
    logic       frame_fcb;
    logic [1:0] timer_cmd;
    logic [1:0] send_outcome;
    logic [1:0] keepalive_outcome;
    logic [1:0] status_report;
    logic [1:0] event_fault;
  } lps_result_t;

endpackage

// ===== hdl/link_primary_station_fsm.sv =====
// Top level of the primary-station link-layer controller: input register,
// one-pass state transition logic and result register. Uses lps_pkg.
//
// A word accepted into the input register passes on to the result register
// and is presented on the out_ ports from there.
// Throughput: one word per cycle while out_stall is low; the transition is a single lookup.
// Reset (rst_n low, synchronous): state idle, flags and retry count cleared,
// retry_limit cleared, both pipeline stages empty.
module link_primary_station_fsm
  import lps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_req_type,
  input  logic       in_tx_success,
  input  logic       in_rx_full,
  input  logic       in_more_segments,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_state_after,
  output logic [2:0] out_frame_cmd,
  output logic       out_frame_fcb,
  output logic [1:0] out_timer_cmd,
  output logic [1:0] out_send_outcome,
  output logic [1:0] out_keepalive_outcome,
  output logic [1:0] out_status_report,
  output logic [1:0] out_event_fault,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  // The configuration register can always be written; software must write it
  // only while the block is idle, which the block itself does not enforce.
  logic [7:0] retry_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      retry_limit_r <= cfg_data;
    end
  end

  // Input register stage. The word in this stage is applied to the state
  // machine at the edge where it moves into the result register, so the
  // following word always sees the state left by this one.
  logic       in_v_r;
  logic [3:0] req_type_r;
  logic       tx_success_r;
  logic       rx_full_r;
  logic       more_segments_r;

  logic        out_v_r;
  lps_result_t out_res_r;

  // The stage advances when it holds a word and the result register is
  // empty or is being emptied in this cycle.
  logic advance;
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_type_r      <= in_req_type;
      tx_success_r    <= in_tx_success;
      rx_full_r       <= in_rx_full;
      more_segments_r <= in_more_segments;
    end
  end

  // Link state kept across words.
  lps_state_t  state_r, state_nxt;
  logic        reset_seen_r, reset_seen_nxt;
  logic        fcb_r, fcb_nxt;
  logic [7:0]  retries_r, retries_nxt;
  lps_result_t res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      reset_seen_r <= 1'b0;
      fcb_r        <= 1'b0;
      retries_r    <= '0;
    end else if (advance) begin
      state_r      <= state_nxt;
      reset_seen_r <= reset_seen_nxt;
      fcb_r        <= fcb_nxt;
      retries_r    <= retries_nxt;
    end
  end

  // Transition logic. Every field of the command word that an event does
  // not drive stays at its "none" code.
  always_comb begin
    state_nxt      = state_r;
    reset_seen_nxt = reset_seen_r;
    fcb_nxt        = fcb_r;
    retries_nxt    = retries_r;

    res_nxt                   = '0;
    res_nxt.frame_cmd         = FRM_NONE;
    res_nxt.frame_fcb         = 1'b0;
    res_nxt.timer_cmd         = TMR_NONE;
    res_nxt.send_outcome      = SEND_NONE;
    res_nxt.keepalive_outcome = KA_NONE;
    res_nxt.status_report     = STAT_NONE;
    res_nxt.event_fault       = FLT_NONE;

    unique case (req_type_r)
      // Send requests outside idle are ignored without a fault.
      EV_SEND_CONF: begin
        if (state_r == ST_IDLE) begin
          retries_nxt = retry_limit_r;
          if (reset_seen_r) begin
            res_nxt.frame_cmd = FRM_CONF_DATA;
            res_nxt.frame_fcb = fcb_r;
            state_nxt         = ST_CONF_TXW;
          end else begin
            res_nxt.frame_cmd = FRM_RESET_LINKS;
            state_nxt         = ST_RESET_TXW;
          end
        end
      end
      EV_SEND_UNCONF: begin
        if (state_r == ST_IDLE) begin
          res_nxt.frame_cmd = FRM_UNCONF_DATA;
          state_nxt         = ST_UNCONF_TXW;
        end
      end
      EV_REQ_STATUS: begin
        if (state_r == ST_IDLE) begin
          res_nxt.frame_cmd = FRM_REQ_STATUS;
          state_nxt         = ST_STATUS_TXW;
        end
      end
      EV_TX_DONE: begin
        unique case (state_r)
          ST_UNCONF_TXW: begin
            // Unconfirmed data streams segment after segment; the outcome
            // reflects only the last transmission.
            if (more_segments_r) begin
              res_nxt.frame_cmd = FRM_UNCONF_DATA;
            end else begin
              res_nxt.send_outcome = tx_success_r ? SEND_OK : SEND_FAIL;
              state_nxt            = ST_IDLE;
            end
          end
          ST_RESET_TXW, ST_CONF_TXW: begin
            if (tx_success_r) begin
              res_nxt.timer_cmd = TMR_START;
              state_nxt = (state_r == ST_RESET_TXW) ? ST_RESET_WAIT : ST_CONF_WAIT;
            end else begin
              res_nxt.send_outcome = SEND_FAIL;
              state_nxt            = ST_IDLE;
            end
          end
          ST_STATUS_TXW: begin
            if (tx_success_r) begin
              res_nxt.timer_cmd = TMR_START;
              state_nxt         = ST_STATUS_WAIT;
            end else begin
              res_nxt.keepalive_outcome = KA_FAIL;
              state_nxt                 = ST_IDLE;
            end
          end
          default: begin
            res_nxt.event_fault = FLT_INVALID;
          end
        endcase
      end
      EV_ACK: begin
        unique case (state_r)
          ST_RESET_WAIT: begin
            // The remote link is now reset: the first confirmed frame goes
            // out with the frame count bit set.
            reset_seen_nxt        = 1'b1;
            fcb_nxt               = 1'b1;
            res_nxt.timer_cmd     = TMR_CANCEL;
            res_nxt.frame_cmd     = FRM_CONF_DATA;
            res_nxt.frame_fcb     = 1'b1;
            res_nxt.status_report = STAT_RESET;
            state_nxt             = ST_CONF_TXW;
          end
          ST_CONF_WAIT: begin
            fcb_nxt           = !fcb_r;
            res_nxt.timer_cmd = TMR_CANCEL;
            if (more_segments_r) begin
              res_nxt.frame_cmd = FRM_CONF_DATA;
              res_nxt.frame_fcb = !fcb_r;
              state_nxt         = ST_CONF_TXW;
            end else begin
              res_nxt.send_outcome = SEND_OK;
              state_nxt            = ST_IDLE;
            end
          end
          default: begin
            res_nxt.event_fault = FLT_UNEXPECTED;
          end
        endcase
      end
      EV_NACK: begin
        unique case (state_r)
          ST_CONF_WAIT: begin
            // The remote side has lost its link reset. A full buffer ends
            // the send; otherwise the link is reset again with fresh retries.
            res_nxt.status_report = STAT_UNRESET;
            res_nxt.timer_cmd     = TMR_CANCEL;
            if (rx_full_r) begin
              res_nxt.send_outcome = SEND_FAIL;
              state_nxt            = ST_IDLE;
            end else begin
              retries_nxt       = retry_limit_r;
              res_nxt.frame_cmd = FRM_RESET_LINKS;
              state_nxt         = ST_RESET_TXW;
            end
          end
          ST_STATUS_WAIT: begin
            res_nxt.timer_cmd         = TMR_CANCEL;
            res_nxt.keepalive_outcome = KA_FAIL;
            state_nxt                 = ST_IDLE;
          end
          default: begin
            res_nxt.event_fault = FLT_UNEXPECTED;
          end
        endcase
      end
      EV_LINK_STATUS, EV_NOT_SUPPORTED: begin
        if (state_r == ST_STATUS_WAIT) begin
          res_nxt.timer_cmd         = TMR_CANCEL;
          res_nxt.keepalive_outcome =
            (req_type_r == EV_LINK_STATUS) ? KA_DONE : KA_FAIL;
          state_nxt                 = ST_IDLE;
        end else begin
          res_nxt.event_fault = FLT_UNEXPECTED;
        end
      end
      EV_TIMEOUT: begin
        unique case (state_r)
          ST_RESET_WAIT: begin
            if (retries_r != '0) begin
              retries_nxt       = retries_r - 8'd1;
              res_nxt.frame_cmd = FRM_RESET_LINKS;
              state_nxt         = ST_RESET_TXW;
            end else begin
              res_nxt.send_outcome = SEND_FAIL;
              state_nxt            = ST_IDLE;
            end
          end
          ST_CONF_WAIT: begin
            if (retries_r != '0) begin
              retries_nxt       = retries_r - 8'd1;
              res_nxt.frame_cmd = FRM_CONF_DATA;
              res_nxt.frame_fcb = fcb_r;
              state_nxt         = ST_CONF_TXW;
            end else begin
              res_nxt.status_report = STAT_UNRESET;
              res_nxt.send_outcome  = SEND_FAIL;
              state_nxt             = ST_IDLE;
            end
          end
          ST_STATUS_WAIT: begin
            res_nxt.keepalive_outcome = KA_FAIL_TIMEOUT;
            state_nxt                 = ST_IDLE;
          end
          default: begin
            res_nxt.event_fault = FLT_INVALID;
          end
        endcase
      end
      // Undefined event codes change nothing and are flagged as invalid.
      default: begin
        res_nxt.event_fault = FLT_INVALID;
      end
    endcase

    res_nxt.state_after = state_nxt;
  end

  // Result register. It holds its word while the receiver stalls, and the
  // input stage keeps accepting until it is itself full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid             = out_v_r;
  assign out_state_after       = out_res_r.state_after;
  assign out_frame_cmd         = out_res_r.frame_cmd;
  assign out_frame_fcb         = out_res_r.frame_fcb;
  assign out_timer_cmd         = out_res_r.timer_cmd;
  assign out_send_outcome      = out_res_r.send_outcome;
  assign out_keepalive_outcome = out_res_r.keepalive_outcome;
  assign out_status_report     = out_res_r.status_report;
  assign out_event_fault       = out_res_r.event_fault;

endmodule
